// ===== rtl/spph_pkg.sv =====
// Shared constants, payload types and helpers for the slow PWM heater controller.
package spph_pkg;

  localparam int TICKS_PER_STEP   = 10;
  localparam int STEPS_PER_PERIOD = 100;

  localparam int TEMP_W   = 12;
  localparam int TARGET_W = 10;
  localparam int DUTY_W   = 7;
  localparam int PRE_W    = $clog2(TICKS_PER_STEP + 1);
  localparam int PER_W    = $clog2(STEPS_PER_PERIOD + 1);
  localparam int GOAL_W   = TARGET_W + 4;
  localparam int DIFF_W   = GOAL_W + 2;
  localparam int NUM_W    = 21;
  localparam int Q_W      = DUTY_W + 1;
  localparam int DSR_W    = GOAL_W + Q_W - 1;
  localparam int CNT_W    = $clog2(Q_W);

  localparam int DUTY_MAX = 100;
  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(30);
  localparam logic signed [TEMP_W:0] TEMP_MIN   = -13'sd880;
  localparam logic signed [TEMP_W:0] SLEW_STEP  = 13'sd16;
  localparam logic signed [TEMP_W-1:0] TEMP_RESET = 12'sd320;

  typedef struct packed {
    logic                     opcode;
    logic signed [TEMP_W-1:0] sample_value;
  } in_beat_t;

  typedef struct packed {
    logic                     heater_on;
    logic [DUTY_W-1:0]        duty_percent;
    logic signed [TEMP_W-1:0] filtered_temp;
  } out_beat_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [GOAL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] quot;
  } div_rsp_t;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  function automatic logic signed [TEMP_W-1:0] slew(input logic signed [TEMP_W-1:0] t,
                                                   input logic signed [TEMP_W-1:0] s);
    logic signed [TEMP_W:0] t13;
    logic signed [TEMP_W:0] s13;
    logic signed [TEMP_W:0] lo;
    logic signed [TEMP_W:0] r;
    t13 = {t[TEMP_W-1], t};
    s13 = {s[TEMP_W-1], s};
    lo  = t13 - SLEW_STEP;
    if (s13 < 0) begin
      r = (lo < TEMP_MIN) ? TEMP_MIN : lo;
    end else if ((s13 - t13) > SLEW_STEP) begin
      r = t13 + SLEW_STEP;
    end else begin
      r = s13;
    end
    return r[TEMP_W-1:0];
  endfunction

endpackage

// ===== rtl/spph_div.sv =====
// Bit-serial restoring divider for the duty ratio, saturating at full duty.
module spph_div (
  input  logic               clk,
  input  logic               rst_n,
  input  spph_pkg::div_req_t req,
  output spph_pkg::div_rsp_t rsp
);

  localparam logic [spph_pkg::CNT_W-1:0] LAST = spph_pkg::CNT_W'(spph_pkg::Q_W - 1);

  logic [spph_pkg::NUM_W-1:0]  rem_r;
  logic [spph_pkg::DSR_W-1:0]  dsr_r;
  logic [spph_pkg::Q_W-1:0]    q_r;
  logic [spph_pkg::CNT_W-1:0]  cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic                        ge;

  assign ge = rem_r >= spph_pkg::NUM_W'(dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      dsr_r <= {req.den, {(spph_pkg::Q_W-1){1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - spph_pkg::NUM_W'(dsr_r);
      end
      dsr_r <= dsr_r >> 1;
      q_r   <= {q_r[spph_pkg::Q_W-2:0], ge};
    end
  end

  always_comb begin
    rsp.done = done_r;
    if (q_r[spph_pkg::Q_W-1] || (q_r[spph_pkg::Q_W-2:0] > spph_pkg::DUTY_W'(spph_pkg::DUTY_MAX)))
    begin
      rsp.quot = spph_pkg::DUTY_W'(spph_pkg::DUTY_MAX);
    end else begin
      rsp.quot = q_r[spph_pkg::Q_W-2:0];
    end
  end

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rsp.quot <= spph_pkg::DUTY_W'(spph_pkg::DUTY_MAX)))
    else $error("duty quotient above full scale");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("division started while busy");
`endif

endmodule

// ===== rtl/slow_pwm_proportional_heater.sv =====
// Top level: slew filter, proportional duty, and slow time-proportioned heater drive.
// Usage:
//   in_*  channel: one beat per event. opcode 0 is a 1 ms tick, opcode 1 a
//         temperature sample in 1/16 C (two's complement).
//   out_* channel: exactly one beat per input beat, in order, carrying the
//         heater level, the duty in percent and the filtered temperature.
//   cfg_* port: target temperature in whole degrees C, written while idle.
// Processing: a tick goes through the push state to the output register. A
//   sample below target first runs the bit-serial divider, one quotient bit
//   per cycle for 8 bits, then goes to the push state; a sample at or above
//   target goes straight to the push state. One item is in work at a time.
// Reset (synchronous, rst_n low): target 30 C, filtered temperature 20 C,
//   duty 0, heater off, prescaler and period counters at their full count.
// Stall: a finished result sits in the output register until taken; a new
//   beat is taken meanwhile, and its result waits in the push state until
//   the output register frees.
module slow_pwm_proportional_heater (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  spph_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output spph_pkg::out_beat_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [spph_pkg::TARGET_W-1:0] cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [spph_pkg::TARGET_W-1:0]     target_r;
  logic signed [spph_pkg::TEMP_W-1:0] temp_r, temp_nxt;
  logic [spph_pkg::DUTY_W-1:0]       duty_r, duty_nxt;
  logic [spph_pkg::PRE_W-1:0]        pre_r, pre_nxt;
  logic [spph_pkg::PER_W-1:0]        per_r, per_nxt;
  logic [spph_pkg::DUTY_W-1:0]       on_r, on_nxt;
  logic                              drive_r, drive_nxt;
  logic                              out_valid_r, out_valid_nxt;
  spph_pkg::out_beat_t               out_data_r, out_data_nxt;

  logic                              in_acc;
  logic                              out_free;
  logic signed [spph_pkg::TEMP_W-1:0] t_new;
  logic [spph_pkg::GOAL_W-1:0]       goal;
  logic signed [spph_pkg::DIFF_W-1:0] diff;
  spph_pkg::div_req_t                div_req;
  spph_pkg::div_rsp_t                div_rsp;

  spph_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign t_new = spph_pkg::slew(temp_r, in_data.sample_value);
  assign goal  = {target_r, 4'b0000};
  assign diff  = $signed({2'b00, goal}) - spph_pkg::DIFF_W'(t_new);

  always_comb begin
    state_nxt     = state_r;
    temp_nxt      = temp_r;
    duty_nxt      = duty_r;
    pre_nxt       = pre_r;
    per_nxt       = per_r;
    on_nxt        = on_r;
    drive_nxt     = drive_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_req.start = 1'b0;
    div_req.num   = spph_pkg::NUM_W'(diff[spph_pkg::DIFF_W-2:0])
                    * spph_pkg::NUM_W'(spph_pkg::DUTY_MAX);
    div_req.den   = goal;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.opcode == spph_pkg::OP_SAMPLE) begin
            temp_nxt = t_new;
            if ((target_r != '0) && (diff > 0)) begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end else begin
              duty_nxt  = '0;
              drive_nxt = 1'b0;
              state_nxt = S_PUSH;
            end
          end else begin
            state_nxt = S_PUSH;
            if (pre_r > spph_pkg::PRE_W'(1)) begin
              pre_nxt = pre_r - 1'b1;
            end else begin
              pre_nxt = spph_pkg::PRE_W'(spph_pkg::TICKS_PER_STEP);
              if (on_r != '0) begin
                on_nxt = on_r - 1'b1;
                if (on_r == spph_pkg::DUTY_W'(1)) begin
                  drive_nxt = 1'b0;
                end
              end
              if (per_r > spph_pkg::PER_W'(1)) begin
                per_nxt = per_r - 1'b1;
              end else begin
                per_nxt = spph_pkg::PER_W'(spph_pkg::STEPS_PER_PERIOD);
                if (duty_r != '0) begin
                  drive_nxt = 1'b1;
                  on_nxt    = duty_r;
                end
              end
            end
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          duty_nxt  = div_rsp.quot;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.heater_on     = drive_r;
          out_data_nxt.duty_percent  = duty_r;
          out_data_nxt.filtered_temp = temp_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      target_r    <= spph_pkg::TARGET_RESET;
      temp_r      <= spph_pkg::TEMP_RESET;
      duty_r      <= '0;
      pre_r       <= spph_pkg::PRE_W'(spph_pkg::TICKS_PER_STEP);
      per_r       <= spph_pkg::PER_W'(spph_pkg::STEPS_PER_PERIOD);
      on_r        <= '0;
      drive_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      temp_r      <= temp_nxt;
      duty_r      <= duty_nxt;
      pre_r       <= pre_nxt;
      per_r       <= per_nxt;
      on_r        <= on_nxt;
      drive_r     <= drive_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r <= spph_pkg::DUTY_W'(spph_pkg::DUTY_MAX))
    else $error("duty above full scale");
  a_temp_floor: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($signed({temp_r[spph_pkg::TEMP_W-1], temp_r}) >= spph_pkg::TEMP_MIN))
    else $error("filtered temperature below floor");
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider result outside division state");
  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r) && $past(rst_n)) |-> $past(state_r == S_PUSH))
    else $error("output beat loaded outside push state");
`endif

endmodule

// ===== dv/spph_heater_checker.sv =====
// Checker for the slow PWM heater controller: predicts each result beat and compares it.
`timescale 1ns / 1ps
module spph_heater_checker
  import spph_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_beat_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_beat_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [TARGET_W-1:0] cfg_wr_data,
  output int                  fail_count,
  output int                  results_due
);

  logic [TARGET_W-1:0]      target_c;
  logic signed [TEMP_W-1:0] filt_temp;
  logic [DUTY_W-1:0]        duty;
  int                       prescale;
  int                       period_left;
  int                       on_left;
  logic                     drive;
  out_beat_t                reports_due[$];
  int                       mismatches = 0;

  function automatic out_beat_t heater_report(input in_beat_t b);
    out_beat_t r;
    int        s;
    int        t;
    int        goal;
    int        d;
    if (b.opcode == OP_SAMPLE) begin
      s = $signed(b.sample_value);
      t = $signed(filt_temp);
      if (s < 0) begin
        t = t - 16;
        if (t < -880) t = -880;
      end else if (s - t > 16) begin
        t = t + 16;
      end else begin
        t = s;
      end
      filt_temp = t[TEMP_W-1:0];
      goal = int'(target_c) * 16;
      if (goal > 0 && t < goal) begin
        d = (goal - t) * 100 / goal;
        if (d > DUTY_MAX) d = DUTY_MAX;
        duty = d[DUTY_W-1:0];
      end else begin
        duty = '0;
        drive = 1'b0;
      end
    end else if (prescale > 1) begin
      prescale--;
    end else begin
      prescale = TICKS_PER_STEP;
      if (on_left != 0) begin
        on_left--;
        if (on_left == 0) drive = 1'b0;
      end
      if (period_left > 1) begin
        period_left--;
      end else begin
        period_left = STEPS_PER_PERIOD;
        if (duty != 0) begin
          drive = 1'b1;
          on_left = duty;
        end
      end
    end
    r.heater_on     = drive;
    r.duty_percent  = duty;
    r.filtered_temp = filt_temp;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_beat_t want;
    if (!rst_n) begin
      target_c    = TARGET_RESET;
      filt_temp   = TEMP_RESET;
      duty        = '0;
      prescale    = TICKS_PER_STEP;
      period_left = STEPS_PER_PERIOD;
      on_left     = 0;
      drive       = 1'b0;
      reports_due.delete();
    end else begin
      // result side first: a beat leaving now belongs to an earlier item
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $error("result beat with no item outstanding: %p", out_data);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          if (out_data.heater_on !== want.heater_on) begin
            $error("heater_on: expected %0b, got %0b", want.heater_on, out_data.heater_on);
            mismatches++;
          end
          if (out_data.duty_percent !== want.duty_percent) begin
            $error("duty_percent: expected %0d, got %0d",
                   want.duty_percent, out_data.duty_percent);
            mismatches++;
          end
          if (out_data.filtered_temp !== want.filtered_temp) begin
            $error("filtered_temp: expected %0d, got %0d",
                   $signed(want.filtered_temp), $signed(out_data.filtered_temp));
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) target_c = cfg_wr_data;
      if (in_valid && !in_stall) reports_due.push_back(heater_report(in_data));
    end
    fail_count  <= mismatches;
    results_due <= reports_due.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the slow PWM heater controller: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
  import spph_pkg::*;

  localparam int PHASE_ITEMS  = 185;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_BLOCK} stall_mode_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_beat_t            in_data;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_beat_t           out_data;
  logic                cfg_wr_en;
  logic [TARGET_W-1:0] cfg_wr_data;
  int                  fail_count;
  int                  results_due;

  int                  burst_left  = 0;
  int                  stall_run   = 0;
  stall_mode_t         stall_mode  = STALL_NONE;
  int                  idle_cycles = 0;
  int                  target_now  = 30;
  int                  last_sample = 320;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  slow_pwm_proportional_heater i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  spph_heater_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run  = $urandom_range(4, 40);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
      STALL_SPARSE: out_stall <= ($urandom_range(0, 7) == 0);
      default:      out_stall <= (stall_run < 24);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("slow_pwm_proportional_heater regression: fail");
        $finish;
      end
    end
  end

  function automatic int clip_temp(input int v);
    if (v < -880) return -880;
    if (v > 2000) return 2000;
    return v;
  endfunction

  // walk: small step from the last reading, at most 20 either way
  function automatic int pick_sample(input bit walk);
    int r;
    r = $urandom_range(0, 9);
    if (walk || r < 3) begin
      last_sample = clip_temp(last_sample + int'($urandom_range(0, 40)) - 20);
    end else if (r < 7) begin
      last_sample = clip_temp(target_now * 16 + int'($urandom_range(0, 320)) - 160);
    end else if (r < 9) begin
      last_sample = int'($urandom_range(0, 2880)) - 880;
    end else begin
      last_sample = 0 - int'($urandom_range(1, 880));
    end
    return last_sample;
  endfunction

  task automatic send_item(input logic op, input int value);
    in_beat_t b;
    int       gap;
    if (op == OP_TICK) value = int'($urandom_range(0, 2880)) - 880;
    b.opcode       = op;
    b.sample_value = value[TEMP_W-1:0];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic set_target(input int t);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t[TARGET_W-1:0];
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    target_now = t;
  endtask

  task automatic random_phase(input int t, input bit cold_snap);
    int sent;
    int r;
    int n;
    set_target(t);
    sent = 0;
    // long run of negative readings drives the filter down toward its floor
    if (cold_snap) begin
      n = $urandom_range(56, 70);
      repeat (n) send_item(OP_SAMPLE, 0 - int'($urandom_range(1, 880)));
      sent += n;
    end
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(0, 199);
      if (r == 0) begin
        drain_results();
      end else if (r < 180) begin
        send_item(OP_TICK, 0);
        sent++;
      end else if (r < 196) begin
        send_item(OP_SAMPLE, pick_sample(1'b0));
        sent++;
      end else begin
        n = $urandom_range(4, 12);
        repeat (n) send_item(OP_SAMPLE, pick_sample(1'b1));
        sent += n;
      end
    end
  endtask

  initial begin
    int opening_samples[10] = '{320, 319, 2000, -880, -1, 0, 336, 32, 49, 1};
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // target 20 C puts the reset temperature right at the target
    set_target(20);
    send_item(OP_TICK, 0);
    foreach (opening_samples[k]) send_item(OP_SAMPLE, opening_samples[k]);
    repeat (9) send_item(OP_TICK, 0);

    random_phase(999, 1'b0);
    random_phase(1, 1'b1);
    random_phase(30, 1'b0);
    random_phase($urandom_range(1, 999), 1'b0);
    random_phase($urandom_range(1, 999), 1'b0);

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("slow_pwm_proportional_heater regression: pass");
    end else begin
      $display("slow_pwm_proportional_heater regression: fail");
    end
    $finish;
  end

endmodule
